// ===== rtl/sorted_insertion_list_unit_macros.svh =====
// Assertion macros used by the sorted insertion list sequencer.
`ifndef SORTED_INSERTION_LIST_UNIT_MACROS_SVH
`define SORTED_INSERTION_LIST_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SIL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted insertion list: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted insertion list: next-cycle check failed");

`endif

// ===== rtl/sil_pkg.sv =====
// Package with types and constants of the sorted insertion list.
`default_nettype none

package sil_pkg;

    localparam int DATA_W           = 32;
    localparam int CAPACITY_DEFAULT = 16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic [1:0]               status;
        logic                     last;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sil_store.sv =====
// Single-port-read, single-port-write value store with registered read data.
`default_nettype none

module sil_store #(
    parameter int DEPTH = sil_pkg::CAPACITY_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [sil_pkg::DATA_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [sil_pkg::DATA_W-1:0] rd_data
);

    logic signed [sil_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sil_ctrl.sv =====
// Sequencer of the sorted insertion list: compare-and-shift insert and ordered dump.
`default_nettype none

`include "sorted_insertion_list_unit_macros.svh"

module sil_ctrl #(
    parameter int CAPACITY = sil_pkg::CAPACITY_DEFAULT,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  sil_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output sil_pkg::rsp_t                     rsp,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic signed [sil_pkg::DATA_W-1:0] wr_data,
    output logic                              rd_en,
    output logic [AW-1:0]                     rd_addr,
    input  logic signed [sil_pkg::DATA_W-1:0] rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_HEAD,
        S_DUMP,
        S_RESP
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [AW-1:0]                     idx_reg, idx_next;
    logic signed [sil_pkg::DATA_W-1:0] val_reg, val_next;
    logic [1:0]                        status_reg, status_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    sil_pkg::rsp_t                     rsp_reg, rsp_next;

    logic slot_free;
    logic stored_lt;
    logic idx_is_last;
    logic req_fire;

    assign req_stall   = (state_reg != S_IDLE);
    assign req_fire    = req_valid && !req_stall;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;
    assign slot_free   = !rsp_valid_reg || !rsp_stall;
    assign stored_lt   = (rd_data < val_reg);
    assign idx_is_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg + AW'(1);
        wr_data        = val_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    val_next = req.value;
                    if (req.kind == sil_pkg::KIND_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = sil_pkg::ST_FULL;
                            state_next  = S_RESP;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = '0;
                            wr_data     = req.value;
                            count_next  = count_reg + CW'(1);
                            status_next = sil_pkg::ST_OK;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - CW'(1));
                            idx_next   = AW'(count_reg - CW'(1));
                            state_next = S_INS_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = sil_pkg::ST_EMPTY;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = S_DUMP;
                        end
                    end
                end
            end

            S_INS_CMP:
            begin
                wr_en = 1'b1;
                if (stored_lt)
                begin
                    wr_data     = val_reg;
                    count_next  = count_reg + CW'(1);
                    status_next = sil_pkg::ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_HEAD;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - AW'(1);
                        idx_next = idx_reg - AW'(1);
                    end
                end
            end

            S_INS_HEAD:
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = val_reg;
                count_next  = count_reg + CW'(1);
                status_next = sil_pkg::ST_OK;
                state_next  = S_RESP;
            end

            S_DUMP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.value_res = rd_data;
                    rsp_next.status    = sil_pkg::ST_OK;
                    rsp_next.last      = idx_is_last;
                    if (idx_is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + AW'(1);
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.value_res = '0;
                    rsp_next.status    = status_reg;
                    rsp_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    `SIL_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `SIL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_fire, req_stall)
    `SIL_ASSERT_NEXT(a_dump_keeps_count, clk, rst_n, state_reg == S_DUMP, $stable(count_reg))
    `SIL_ASSERT_SAME(a_write_in_range, clk, rst_n, wr_en, CW'(wr_addr) <= count_reg)

endmodule

`default_nettype wire

// ===== rtl/sorted_insertion_list_unit.sv =====
// Top level of the sorted insertion list: sequencer and value store.
// An insert into an empty store, an insert into a full store and a dump of an empty store
// each answer with a single result after the transfer cycle. Any other insert compares
// the stored values with the new one, one at a time from the last one down through the
// store's single read port, and moves each one not less than the new one up an entry;
// it ends when it finds a smaller value or writes the head entry, and then gives its status
// result. A dump delivers one value per cycle when the result side does not stall. The
// next request is taken only after the last result of the current one is in the output
// register.
`default_nettype none

module sorted_insertion_list_unit #(
    parameter int CAPACITY = sil_pkg::CAPACITY_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sil_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sil_pkg::rsp_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [sil_pkg::DATA_W-1:0] wr_data;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic signed [sil_pkg::DATA_W-1:0] rd_data;

    sil_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    sil_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ===== dv/sorted_insertion_list_unit_test.sv =====
// Self-checking testbench for the sorted insertion list with random stimulus and stalls.
`default_nettype none

module sorted_insertion_list_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 29;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 2000;
    localparam int TAIL_CYCLES = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    sil_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    sil_pkg::rsp_t rsp;

    sil_pkg::req_t pending_ops[$];
    sil_pkg::rsp_t expected_rsps[$];
    logic signed [sil_pkg::DATA_W-1:0] sorted_vals[$];

    int n_queued = 0;
    int n_accepted = 0;
    int errors = 0;
    int stuck_cycles = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    bit no_idle = 1'b0;
    bit req_accepted = 1'b0;

    sorted_insertion_list_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void predict_list_op(sil_pkg::req_t op);
        sil_pkg::rsp_t r;
        int pos;
        r = '0;
        if (op.kind == sil_pkg::KIND_INSERT)
        begin
            if (sorted_vals.size() >= sil_pkg::CAPACITY_DEFAULT)
                r.status = sil_pkg::ST_FULL;
            else
            begin
                pos = 0;
                while (pos < sorted_vals.size() && sorted_vals[pos] < op.value)
                    pos++;
                sorted_vals.insert(pos, op.value);
                r.status = sil_pkg::ST_OK;
            end
            r.last = 1'b1;
            expected_rsps.push_back(r);
        end
        else if (sorted_vals.size() == 0)
        begin
            r.status = sil_pkg::ST_EMPTY;
            r.last = 1'b1;
            expected_rsps.push_back(r);
        end
        else
        begin
            foreach (sorted_vals[i])
            begin
                r.value_res = sorted_vals[i];
                r.status = sil_pkg::ST_OK;
                r.last = (i == sorted_vals.size() - 1);
                expected_rsps.push_back(r);
            end
        end
    endfunction

    function automatic void check_list_rsp(sil_pkg::rsp_t got);
        sil_pkg::rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            $error("unexpected result: value_res %0d status %0d last %0d",
                   got.value_res, got.status, got.last);
            errors++;
            return;
        end
        want = expected_rsps.pop_front();
        if (got.value_res !== want.value_res)
        begin
            $error("value_res: expected %0d, got %0d", want.value_res, got.value_res);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
        end
    endfunction

    // Acceptance, prediction, checking and the watchdog, all at the rising edge.
    always @(posedge clk)
    begin
        req_accepted = 1'b0;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                req_accepted = 1'b1;
                n_accepted++;
                predict_list_op(req);
            end
            if (rsp_valid && !rsp_stall)
                check_list_rsp(rsp);
            if (req_accepted || (rsp_valid && !rsp_stall))
                stuck_cycles = 0;
            else if (n_accepted != n_queued || expected_rsps.size() != 0)
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!req_valid || req_accepted)
        begin
            if (pending_ops.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                req <= pending_ops.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic queue_op(logic kind, logic signed [sil_pkg::DATA_W-1:0] v);
        sil_pkg::req_t op;
        op.kind = kind;
        op.value = v;
        pending_ops.push_back(op);
        n_queued++;
    endtask

    task automatic queue_random_ops(int n);
        logic kind;
        logic signed [sil_pkg::DATA_W-1:0] v;
        repeat (n)
        begin
            kind = ($urandom_range(99) < 35) ? sil_pkg::KIND_DUMP : sil_pkg::KIND_INSERT;
            case ($urandom_range(7))
                0, 1: v = int'($urandom_range(6)) - 3;
                2: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
                default: v = $urandom;
            endcase
            queue_op(kind, v);
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_op(sil_pkg::KIND_DUMP, $urandom);
        queue_op(sil_pkg::KIND_INSERT, 0);
        queue_op(sil_pkg::KIND_INSERT, 32'sh7fffffff);
        queue_op(sil_pkg::KIND_INSERT, 32'sh80000000);
        queue_op(sil_pkg::KIND_INSERT, -1);
        queue_op(sil_pkg::KIND_DUMP, $urandom);
        queue_op(sil_pkg::KIND_INSERT, 0);
        queue_op(sil_pkg::KIND_INSERT, 32'sh7fffffff);
        queue_op(sil_pkg::KIND_INSERT, 32'sh55555555);
        queue_op(sil_pkg::KIND_DUMP, $urandom);
        wait_drained();

        queue_random_ops(200);
        holds_asked = holds_asked + 1;
        wait_drained();

        no_idle = 1'b1;
        queue_random_ops(100);
        wait_drained();
        no_idle = 1'b0;

        queue_random_ops(200);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
